// ===== hw/rtl/cbst_pkg.sv =====
// cbst_pkg: shared types and constants for the bus cycle strobe timing block
// holds the transaction structs, bus operation codes and T-state numbers; no dependencies
package cbst_pkg;

    localparam int unsigned BYTE_BITS = 8;

    // bus operation codes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_FETCH = 3'd1;
    localparam logic [2:0] MODE_MRD   = 3'd2;
    localparam logic [2:0] MODE_MWR   = 3'd3;
    localparam logic [2:0] MODE_IORD  = 3'd4;
    localparam logic [2:0] MODE_IOWR  = 3'd5;
    localparam logic [2:0] MODE_INTA  = 3'd6;

    // T-state numbers used by the strobe windows
    localparam logic [3:0] T1 = 4'd1;
    localparam logic [3:0] T2 = 4'd2;
    localparam logic [3:0] T3 = 4'd3;
    localparam logic [3:0] T4 = 4'd4;

    typedef struct packed {
        logic [2:0]           mode;
        logic [3:0]           tstate_index;
        logic                 half_phase;
        logic [15:0]          cycle_address;
        logic [BYTE_BITS-1:0] write_byte;
        logic [BYTE_BITS-1:0] refresh_high;
        logic [BYTE_BITS-1:0] refresh_low;
    } t_bus_in;

    typedef struct packed {
        logic [15:0]          bus_address;
        logic [BYTE_BITS-1:0] bus_data;
        logic                 data_enable;
        logic                 fetch_strobe_n;
        logic                 memreq_n;
        logic                 ioreq_n;
        logic                 read_n;
        logic                 write_n;
        logic                 refresh_n;
    } t_bus_out;

endpackage

// ===== hw/rtl/cpu_bus_cycle_strobe_timing.sv =====
// cpu_bus_cycle_strobe_timing: bus pin decode behind an input and a result register
// depends on cbst_pkg and cbst_decode
// an accepted input transaction is held in the input register, decoded, then held in the result register
// throughput: one transaction per cycle while i_out_ready stays high, set by the single-pass decode between registers
// both register stages advance whenever the stage after them is empty or being drained
// reset (i_rst_n low, synchronous) empties both stages; payload registers are not cleared
module cpu_bus_cycle_strobe_timing (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cbst_pkg::t_bus_in   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cbst_pkg::t_bus_out  o_out_item
);
    import cbst_pkg::*;

    // input stage
    logic     r_in_valid;
    t_bus_in  r_in_item;
    // result stage
    logic     r_out_valid;
    t_bus_out r_out_item;

    logic     n_in_valid;
    logic     n_out_valid;
    logic     w_out_load;
    logic     w_in_load;
    t_bus_out w_decoded;

    // result register takes a new value when empty or when its transaction leaves
    assign w_out_load = !r_out_valid || i_out_ready;
    // input register can take a transaction when empty or when it moves on
    assign o_in_ready = !r_in_valid || w_out_load;
    assign w_in_load  = i_in_valid && o_in_ready;

    cbst_decode u_decode (
        .i_item (r_in_item),
        .o_item (w_decoded)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
        if (w_out_load) begin
            n_out_valid = r_in_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in_item <= i_in_item;
        end
        if (w_out_load && r_in_valid) begin
            r_out_item <= w_decoded;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a decoded transaction moving forward shows up as a valid result next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_load) |=> o_out_valid)
        else $error("decoded transaction lost between stages");

    // refresh and opcode fetch markers never overlap
    a_rfsh_m1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.refresh_n || o_out_item.fetch_strobe_n))
        else $error("refresh and fetch marker both low");

    // data is only driven in write cycles, never with a read strobe
    a_drive_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.data_enable) |-> o_out_item.read_n)
        else $error("data driven during a read");

    // reset empties both stages
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("stage still valid after reset");

endmodule

// ===== hw/rtl/cbst_decode.sv =====
// cbst_decode: pin decode for one bus half-phase, purely combinational
// depends on cbst_pkg for the transaction structs and operation codes
module cbst_decode (
    input  cbst_pkg::t_bus_in  i_item,
    output cbst_pkg::t_bus_out o_item
);
    import cbst_pkg::*;

    logic [3:0] w_t;
    logic       w_p;
    logic       w_n;
    logic       w_m1;
    logic       w_mreq;
    logic       w_iorq;
    logic       w_rd;
    logic       w_wr;
    logic       w_rfsh;
    logic       w_drive;
    logic       w_use_rfsh_addr;
    logic       w_fetch_lo;
    logic       w_refr_lo;
    logic       w_mem_act;
    logic       w_io_act;

    assign w_t = i_item.tstate_index;
    assign w_p = !i_item.half_phase;
    assign w_n = i_item.half_phase;

    // window terms; the memory and I/O windows are shared by their read and write codes
    assign w_fetch_lo = (w_t == T1 && w_n) || (w_t == T2);
    assign w_refr_lo  = (w_t == T3 && w_n) || (w_t == T4 && w_p);
    assign w_mem_act  = !(w_t == T1 && w_p) && !(w_t == T3 && w_n) && (w_t <= T3);
    assign w_io_act   = (w_t >= T2) && (w_t <= T4) && !(w_t == T4 && w_n);

    always_comb begin
        w_m1            = 1'b0;
        w_mreq          = 1'b0;
        w_iorq          = 1'b0;
        w_rd            = 1'b0;
        w_wr            = 1'b0;
        w_rfsh          = 1'b0;
        w_drive         = 1'b0;
        w_use_rfsh_addr = 1'b0;
        unique case (i_item.mode)
            MODE_FETCH: begin
                w_use_rfsh_addr = (w_t >= T3);
                w_m1            = (w_t <= T2);
                w_rfsh          = (w_t >= T3);
                w_mreq          = w_fetch_lo || w_refr_lo;
                w_rd            = w_fetch_lo;
            end
            MODE_MRD: begin
                w_mreq = w_mem_act;
                w_rd   = w_mem_act;
            end
            MODE_MWR: begin
                w_mreq  = w_mem_act;
                w_drive = w_mem_act;
                w_wr    = (w_t == T2 && w_n) || (w_t == T3 && w_p);
            end
            MODE_IORD: begin
                w_iorq = w_io_act;
                w_rd   = w_io_act;
            end
            MODE_IOWR: begin
                w_iorq  = w_io_act;
                w_drive = !(w_t == T1 && w_p) && (w_t <= T4);
                w_wr    = (w_t == T2 && w_n) || (w_t == T3) || (w_t == T4 && w_p);
            end
            MODE_INTA: begin
                w_m1   = (w_t <= T2);
                w_iorq = (w_t >= T3);
            end
            default: begin
                // idle and unused codes leave every strobe inactive
            end
        endcase
    end

    assign o_item.bus_address    = w_use_rfsh_addr ? {i_item.refresh_high, i_item.refresh_low}
                                                   : i_item.cycle_address;
    assign o_item.bus_data       = i_item.write_byte;
    assign o_item.data_enable    = w_drive;
    assign o_item.fetch_strobe_n = !w_m1;
    assign o_item.memreq_n       = !w_mreq;
    assign o_item.ioreq_n        = !w_iorq;
    assign o_item.read_n         = !w_rd;
    assign o_item.write_n        = !w_wr;
    assign o_item.refresh_n      = !w_rfsh;

endmodule

// ===== bench/cbst_checker.sv =====
// cbst_checker: watches both channels of the bus strobe decode, predicts each result
// and compares it field by field; depends on cbst_pkg only
`timescale 1ns / 1ps

module cbst_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  cbst_pkg::t_bus_in   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cbst_pkg::t_bus_out  i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import cbst_pkg::*;

    localparam logic PHASE_POS = 1'b0;

    t_bus_out expected_pins[$];
    int       mismatches = 0;

    // pin values for one clock half-phase
    function automatic t_bus_out predict_bus_pins(input t_bus_in bus);
        t_bus_out   pins;
        logic [3:0] t;
        logic       pos, neg, mem_win, io_win, fetch_win, refresh_win;
        logic       m1, mreq, iorq, rd, wr, rfsh, drive;
        t     = bus.tstate_index;
        pos   = (bus.half_phase == PHASE_POS);
        neg   = !pos;
        m1    = 1'b0;
        mreq  = 1'b0;
        iorq  = 1'b0;
        rd    = 1'b0;
        wr    = 1'b0;
        rfsh  = 1'b0;
        drive = 1'b0;
        pins.bus_address = bus.cycle_address;
        // t-state zero falls inside the "up to" windows but is never T1
        mem_win = !(t == T1 && pos) && !(t == T3 && neg) && (t <= T3);
        io_win  = (t >= T2) && (t <= T4) && !(t == T4 && neg);
        case (bus.mode)
            MODE_FETCH: begin
                fetch_win   = (t == T1 && neg) || (t == T2);
                refresh_win = (t == T3 && neg) || (t == T4 && pos);
                if (t >= T3) begin
                    pins.bus_address = {bus.refresh_high, bus.refresh_low};
                end
                m1   = (t <= T2);
                rfsh = (t >= T3);
                mreq = fetch_win || refresh_win;
                rd   = fetch_win;
            end
            MODE_MRD: begin
                mreq = mem_win;
                rd   = mem_win;
            end
            MODE_MWR: begin
                mreq  = mem_win;
                drive = mem_win;
                wr    = (t == T2 && neg) || (t == T3 && pos);
            end
            MODE_IORD: begin
                iorq = io_win;
                rd   = io_win;
            end
            MODE_IOWR: begin
                iorq  = io_win;
                drive = !(t == T1 && pos) && (t <= T4);
                wr    = (t == T2 && neg) || (t == T3) || (t == T4 && pos);
            end
            MODE_INTA: begin
                m1   = (t <= T2);
                iorq = (t >= T3);
            end
            default: begin
                // idle and the unused code leave every strobe high
            end
        endcase
        pins.bus_data       = bus.write_byte;
        pins.data_enable    = drive;
        pins.fetch_strobe_n = !m1;
        pins.memreq_n       = !mreq;
        pins.ioreq_n        = !iorq;
        pins.read_n         = !rd;
        pins.write_n        = !wr;
        pins.refresh_n      = !rfsh;
        return pins;
    endfunction

    task automatic check_pin_field(input string name, input logic [15:0] want,
                                   input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_bus_out want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pins.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result expected none actual %h",
                             $time, i_out_item);
                end else begin
                    want = expected_pins.pop_front();
                    check_pin_field("bus_address", want.bus_address, i_out_item.bus_address);
                    check_pin_field("bus_data", 16'(want.bus_data),
                                    16'(i_out_item.bus_data));
                    check_pin_field("data_enable", 16'(want.data_enable),
                                    16'(i_out_item.data_enable));
                    check_pin_field("fetch_strobe_n", 16'(want.fetch_strobe_n),
                                    16'(i_out_item.fetch_strobe_n));
                    check_pin_field("memreq_n", 16'(want.memreq_n),
                                    16'(i_out_item.memreq_n));
                    check_pin_field("ioreq_n", 16'(want.ioreq_n),
                                    16'(i_out_item.ioreq_n));
                    check_pin_field("read_n", 16'(want.read_n),
                                    16'(i_out_item.read_n));
                    check_pin_field("write_n", 16'(want.write_n),
                                    16'(i_out_item.write_n));
                    check_pin_field("refresh_n", 16'(want.refresh_n),
                                    16'(i_out_item.refresh_n));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_pins.push_back(predict_bus_pins(i_in_item));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_pins.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: stimulus and verdict for the bus strobe decode
// depends on cbst_pkg, cpu_bus_cycle_strobe_timing and cbst_checker
`timescale 1ns / 1ps

module tb_top;
    import cbst_pkg::*;

    // the one bus operation code the package leaves unnamed
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 550;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_bus_in   in_item;
    logic      out_valid;
    logic      out_ready;
    t_bus_out  out_item;
    int        fail_count;
    int        pending;

    // both sides stop idling while this is set
    logic      steady;

    cpu_bus_cycle_strobe_timing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // checker sees exactly what crosses each channel
    cbst_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side back-pressure, changed on the falling edge only
    always @(negedge i_clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 22);
    end

    // one input transaction: optional idle gap, then hold valid until accepted
    task automatic send_bus_item(input logic [2:0] mode, input logic [3:0] t,
                                 input logic ph, input logic [15:0] addr,
                                 input logic [7:0] wbyte, input logic [7:0] rhi,
                                 input logic [7:0] rlo);
        t_bus_in bus;
        bus.mode          = mode;
        bus.tstate_index  = t;
        bus.half_phase    = ph;
        bus.cycle_address = addr;
        bus.write_byte    = wbyte;
        bus.refresh_high  = rhi;
        bus.refresh_low   = rlo;
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 22) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= bus;
        do begin
            @(posedge i_clk);
        end while (!(in_valid && in_ready));
    endtask

    // safety net against a hung handshake
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          sent;
        int          cycle_len;
        logic [2:0]  mode;
        logic [15:0] addr;
        logic [7:0]  wbyte, rhi, rlo;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        steady    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every operation and the corner t-states
        send_bus_item(MODE_NONE,   4'd1,  1'b0, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_bus_item(MODE_FETCH,  4'd1,  1'b1, 16'hffff, 8'hff, 8'hff, 8'hff);
        send_bus_item(MODE_FETCH,  4'd3,  1'b0, 16'h1234, 8'h3c, 8'ha5, 8'h5a);
        send_bus_item(MODE_FETCH,  4'd4,  1'b1, 16'hfedc, 8'hc3, 8'h5a, 8'ha5);
        // beyond the end of a fetch the refresh address and strobe remain
        send_bus_item(MODE_FETCH,  4'd15, 1'b1, 16'h8001, 8'h81, 8'h80, 8'h01);
        // t-state zero sits inside the early windows
        send_bus_item(MODE_MRD,    4'd0,  1'b0, 16'h4000, 8'h40, 8'h12, 8'h34);
        send_bus_item(MODE_MRD,    4'd1,  1'b0, 16'h4001, 8'h41, 8'h12, 8'h34);
        send_bus_item(MODE_MRD,    4'd3,  1'b1, 16'h4002, 8'h42, 8'h12, 8'h34);
        send_bus_item(MODE_MWR,    4'd2,  1'b1, 16'hc000, 8'h99, 8'h00, 8'hff);
        send_bus_item(MODE_MWR,    4'd3,  1'b0, 16'hc001, 8'h66, 8'hff, 8'h00);
        send_bus_item(MODE_IORD,   4'd4,  1'b0, 16'h00fe, 8'h11, 8'h22, 8'h33);
        send_bus_item(MODE_IORD,   4'd4,  1'b1, 16'h00fe, 8'h11, 8'h22, 8'h33);
        send_bus_item(MODE_IOWR,   4'd1,  1'b1, 16'h01fe, 8'h55, 8'h44, 8'h77);
        send_bus_item(MODE_IOWR,   4'd3,  1'b1, 16'h02fe, 8'haa, 8'h44, 8'h77);
        send_bus_item(MODE_IOWR,   4'd5,  1'b0, 16'h03fe, 8'h5a, 8'h44, 8'h77);
        send_bus_item(MODE_INTA,   4'd2,  1'b1, 16'h7fff, 8'h7f, 8'h0f, 8'hf0);
        send_bus_item(MODE_INTA,   4'd3,  1'b0, 16'h8000, 8'h80, 8'hf0, 8'h0f);
        send_bus_item(MODE_INTA,   4'd15, 1'b0, 16'hffff, 8'hff, 8'hff, 8'hff);
        // unused operation code behaves as an idle cycle
        send_bus_item(MODE_UNUSED, 4'd2,  1'b1, 16'hbeef, 8'hef, 8'hbe, 8'hef);
        send_bus_item(MODE_NONE,   4'd15, 1'b1, 16'hffff, 8'hff, 8'hff, 8'hff);

        // random: mostly complete machine cycles walked half-phase by half-phase,
        // the rest single transactions with every field at random
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (sent >= 200 && sent < 320);
            if ($urandom_range(0, 99) < 85) begin
                mode      = 3'($urandom_range(0, 6));
                cycle_len = $urandom_range(3, 6);
                addr      = 16'($urandom);
                wbyte     = 8'($urandom);
                rhi       = 8'($urandom);
                rlo       = 8'($urandom);
                for (int t = 1; t <= cycle_len; t++) begin
                    for (int ph = 0; ph < 2; ph++) begin
                        send_bus_item(mode, 4'(t), 1'(ph), addr, wbyte, rhi, rlo);
                        sent++;
                    end
                end
            end else begin
                send_bus_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                sent++;
            end
        end
        steady = 1'b0;

        @(negedge i_clk);
        in_valid <= 1'b0;

        // drain, then give the two register stages time to show any stray result
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cbst_pkg.sv
hw/rtl/cbst_decode.sv
hw/rtl/cpu_bus_cycle_strobe_timing.sv
bench/cbst_checker.sv
bench/tb_top.sv
